/* rtl/core/bfoc_pkg.sv */
// Shared types and constants for the box frustum outcode cull block.
`default_nettype none
package bfoc_pkg;

  localparam int unsigned CORNERS = 8;
  localparam int unsigned CNT_W   = 3;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CORNERS - 1);

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned ADDR_W   = 6;

  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

  localparam logic [63:0] MVP_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

  typedef logic [1:0] side_t;
  localparam side_t SIDE_IN  = 2'b00;
  localparam side_t SIDE_POS = 2'b01;
  localparam side_t SIDE_NEG = 2'b11;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_SIDE = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  localparam logic [4:0] MAC_LAST = 5'd16;

  localparam logic [1:0] SUB_W = 2'd0;
  localparam logic [1:0] SUB_X = 2'd1;
  localparam logic [1:0] SUB_Y = 2'd2;

endpackage
`default_nettype wire

/* rtl/core/box_frustum_outcode_cull.sv */
// Top level of the box frustum outcode cull block.
//
//  channel   | dir | handshake             | payload
//  s_axis    | in  | tvalid/tready         | tdata[127:0] = corner_x, y, z, w
//  m_axis    | out | tvalid/tready         | tdata[7:0]   = box_visible in bit 0
//  apb       | in  | psel/penable/pready   | 64-bit mvp matrix registers at 8*i
//
// A corner is accepted in IDLE; MAC then runs the sixteen multiply-accumulates on the
// shared 32x32 multiplier, SIDE uses the shared magnitude logic for w, x/w and y/w
// in turn, and DONE updates the outcode state.
// Reset loads the identity matrix and clears the corner count; no clearing pass.
// A pending result holds the block only when the next box result is due.
`default_nettype none
module box_frustum_outcode_cull (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: corner_x[31:0], corner_y[63:32], corner_z[95:64], corner_w[127:96]
  input  wire logic [127:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: box_visible[0], zero fill [7:1]
  output logic [7:0]        m_axis_tdata,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [bfoc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [63:0] mvp_q [bfoc_pkg::NUM_REGS];
  logic [2:0]  reg_idx;

  bfoc_pkg::state_e state_q, state_d;

  logic [31:0] p_q [4];
  logic [4:0]  step_q;
  logic [1:0]  sub_q;
  logic [63:0] prod_q;
  logic [63:0] acc_q;
  logic [63:0] c_q [4];
  logic [63:0] wmag_q;
  logic        wneg_q;

  bfoc_pkg::side_t sx_q, sy_q, sz_q;
  bfoc_pkg::side_t fx_q, fy_q, fz_q;
  bfoc_pkg::side_t fx_d, fy_d, fz_d;
  logic [2:0]  flags_q, flags_d;
  logic [bfoc_pkg::CNT_W-1:0] cnt_q;

  logic        out_valid_q;
  logic        out_vis_q;

  logic [1:0]  row_s, col_s;
  logic [3:0]  prev_s;
  logic [63:0] ent_pair;
  logic [31:0] ent;
  logic [63:0] mul_res;
  logic [63:0] acc_sum;

  logic [63:0] num;
  logic        nneg;
  logic [63:0] nmag;
  bfoc_pkg::side_t side_n;
  bfoc_pkg::side_t side_zc;

  logic        last;
  logic        culled;
  logic        done_go;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign prdata  = mvp_q[reg_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bfoc_pkg::NUM_REGS; i++) begin
        mvp_q[i] <= bfoc_pkg::MVP_RESET[i];
      end
    end else if (psel && penable && pwrite) begin
      mvp_q[reg_idx] <= pwdata;
    end
  end

  assign row_s    = step_q[3:2];
  assign col_s    = step_q[1:0];
  assign prev_s   = step_q[3:0] - 4'd1;
  assign ent_pair = mvp_q[{row_s, col_s[1]}];
  assign ent      = col_s[0] ? ent_pair[63:32] : ent_pair[31:0];
  assign mul_res  = 64'($signed(ent) * $signed(p_q[col_s]));
  assign acc_sum  = (prev_s[1:0] == 2'd0) ? prod_q : acc_q + prod_q;

  assign num  = (sub_q == bfoc_pkg::SUB_W) ? c_q[3] :
                (sub_q == bfoc_pkg::SUB_X) ? c_q[0] : c_q[1];
  assign nneg = num[63];
  assign nmag = nneg ? (64'd0 - num) : num;

  always_comb begin
    if (nmag <= wmag_q) begin
      side_n = bfoc_pkg::SIDE_IN;
    end else if (nneg != wneg_q) begin
      side_n = bfoc_pkg::SIDE_NEG;
    end else begin
      side_n = bfoc_pkg::SIDE_POS;
    end
  end

  always_comb begin
    if (c_q[2][63]) begin
      side_zc = bfoc_pkg::SIDE_NEG;
    end else if (c_q[2] > bfoc_pkg::ONE_Q32) begin
      side_zc = bfoc_pkg::SIDE_POS;
    end else begin
      side_zc = bfoc_pkg::SIDE_IN;
    end
  end

  always_comb begin
    if (cnt_q == '0) begin
      fx_d    = sx_q;
      fy_d    = sy_q;
      fz_d    = sz_q;
      flags_d = 3'b111;
    end else begin
      fx_d    = fx_q;
      fy_d    = fy_q;
      fz_d    = fz_q;
      flags_d = flags_q;
      if (sx_q != fx_q) flags_d[0] = 1'b0;
      if (sy_q != fy_q) flags_d[1] = 1'b0;
      if (sz_q != fz_q) flags_d[2] = 1'b0;
    end
  end

  assign last    = cnt_q >= bfoc_pkg::LAST_CNT;
  assign culled  = (flags_d[0] && (fx_d != bfoc_pkg::SIDE_IN)) ||
                   (flags_d[1] && (fy_d != bfoc_pkg::SIDE_IN)) ||
                   (flags_d[2] && (fz_d != bfoc_pkg::SIDE_POS));
  assign done_go = !last || !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bfoc_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = bfoc_pkg::ST_MAC;
      end
      bfoc_pkg::ST_MAC: begin
        if (step_q == bfoc_pkg::MAC_LAST) state_d = bfoc_pkg::ST_SIDE;
      end
      bfoc_pkg::ST_SIDE: begin
        if (sub_q == bfoc_pkg::SUB_Y) state_d = bfoc_pkg::ST_DONE;
      end
      bfoc_pkg::ST_DONE: begin
        if (done_go) state_d = bfoc_pkg::ST_IDLE;
      end
      default: state_d = bfoc_pkg::ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == bfoc_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfoc_pkg::ST_IDLE;
      step_q      <= '0;
      sub_q       <= bfoc_pkg::SUB_W;
      cnt_q       <= '0;
      fx_q        <= bfoc_pkg::SIDE_IN;
      fy_q        <= bfoc_pkg::SIDE_IN;
      fz_q        <= bfoc_pkg::SIDE_IN;
      flags_q     <= 3'b111;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == bfoc_pkg::ST_DONE && done_go && last) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        bfoc_pkg::ST_IDLE: begin
          step_q <= '0;
          sub_q  <= bfoc_pkg::SUB_W;
        end
        bfoc_pkg::ST_MAC: begin
          step_q <= step_q + 5'd1;
        end
        bfoc_pkg::ST_SIDE: begin
          sub_q <= sub_q + 2'd1;
        end
        bfoc_pkg::ST_DONE: begin
          if (done_go) begin
            fx_q    <= fx_d;
            fy_q    <= fy_d;
            fz_q    <= fz_d;
            flags_q <= flags_d;
            if (last) begin
              cnt_q <= '0;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        default: begin
          step_q <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      p_q[0] <= s_axis_tdata[31:0];
      p_q[1] <= s_axis_tdata[63:32];
      p_q[2] <= s_axis_tdata[95:64];
      p_q[3] <= s_axis_tdata[127:96];
    end
    if (state_q == bfoc_pkg::ST_MAC) begin
      if (step_q != bfoc_pkg::MAC_LAST) prod_q <= mul_res;
      if (step_q != 5'd0) begin
        acc_q <= acc_sum;
        if (prev_s[1:0] == 2'd3) c_q[prev_s[3:2]] <= acc_sum;
      end
    end
    if (state_q == bfoc_pkg::ST_SIDE) begin
      case (sub_q)
        bfoc_pkg::SUB_W: begin
          wmag_q <= nmag;
          wneg_q <= nneg;
          sz_q   <= side_zc;
        end
        bfoc_pkg::SUB_X: sx_q <= side_n;
        bfoc_pkg::SUB_Y: sy_q <= side_n;
        default: sy_q <= side_n;
      endcase
    end
    if (state_q == bfoc_pkg::ST_DONE && done_go && last) begin
      out_vis_q <= !culled;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_vis_q};

endmodule
`default_nettype wire
